/* rtl/stepper_phase_sequencer_defines.svh */
// Assertion macros for the stepper phase sequencer checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef STEPPER_PHASE_SEQUENCER_DEFINES_SVH
`define STEPPER_PHASE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sps_pkg.sv */
// Shared types, constants and coil pattern tables for the stepper phase sequencer.
// No dependencies; compiled before the channel interfaces and modules.
`timescale 1ns / 1ps

package sps_pkg;

  localparam int COUNT_WIDTH = 32;

  localparam int CMD_W      = 2;
  localparam int ANGLE_W    = 24;
  localparam int DELAY_W    = 16;
  localparam int SPR_W      = 20;
  localparam int COILS_W    = 4;
  localparam int PHASE_W    = 3;
  localparam int ACC_W      = ANGLE_W + SPR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int DEG_SIXTEENTHS = 360 * 16;

  localparam logic [ACC_W-1:0] STEP_UNIT    = ACC_W'(DEG_SIXTEENTHS);
  localparam logic [ACC_W-1:0] FINISH_LIMIT = ACC_W'(2 * DEG_SIXTEENTHS);
  localparam logic [63:0]      STEP_CAP     =
    ((64'd1 << COUNT_WIDTH) * 64'(DEG_SIXTEENTHS)) - 64'd1;

  localparam logic [CFG_IDX_W-1:0] REG_COIL_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_STEPS = 2'd1;

  localparam logic [1:0] MODE_WAVE = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;

  localparam logic [SPR_W-1:0] HALF_STEPS_RESET = 20'd4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  function automatic logic [COILS_W-1:0] wave_pattern(input logic [1:0] p);
    logic [COILS_W-1:0] c;
    case (p)
      2'd0:    c = 4'h1;
      2'd1:    c = 4'h2;
      2'd2:    c = 4'h4;
      default: c = 4'h8;
    endcase
    return c;
  endfunction

  function automatic logic [COILS_W-1:0] full_pattern(input logic [1:0] p);
    logic [COILS_W-1:0] c;
    case (p)
      2'd0:    c = 4'h3;
      2'd1:    c = 4'h6;
      2'd2:    c = 4'hC;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

  function automatic logic [COILS_W-1:0] half_pattern(input logic [PHASE_W-1:0] p);
    logic [COILS_W-1:0] c;
    case (p)
      3'd0:    c = 4'h1;
      3'd1:    c = 4'h3;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h4;
      3'd5:    c = 4'hC;
      3'd6:    c = 4'h8;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

endpackage

/* rtl/sps_cfg_if.sv */
// Configuration write channel: register index and write data with valid and ready.
// Depends on sps_pkg for the field widths.
`timescale 1ns / 1ps

interface sps_cfg_if import sps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/sps_in_if.sv */
// Command channel: one command transaction with its move fields.
// Depends on sps_pkg for the field widths.
`timescale 1ns / 1ps

interface sps_in_if import sps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [ANGLE_W-1:0] angle_sixteenths;
  logic [DELAY_W-1:0]        step_delay_ms;

  modport source (output valid, output command, output angle_sixteenths,
                  output step_delay_ms, input ready);
  modport sink (input valid, input command, input angle_sixteenths,
                input step_delay_ms, output ready);
endinterface

/* rtl/sps_out_if.sv */
// Result channel: coil drive and move status for each command transaction.
// Depends on sps_pkg for the field widths.
`timescale 1ns / 1ps

interface sps_out_if import sps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COILS_W-1:0] coils;
  logic               running;
  logic               done_res;
  logic               status;

  modport source (output valid, output coils, output running, output done_res,
                  output status, input ready);
  modport sink (input valid, input coils, input running, input done_res,
                input status, output ready);
endinterface

/* rtl/stepper_phase_sequencer.sv */
// Top level of the stepper phase sequencer: command decode, step timing and coil drive.
// Depends on sps_pkg and the sps_cfg_if, sps_in_if and sps_out_if channel interfaces.
`timescale 1ns / 1ps

// Every command transaction (start, cancel or millisecond tick) yields exactly one result
// transaction carrying the coil drive, the running flag, the done flag and the cancel status.
// A transaction is captured in an input register and its result is then written to the output
// register, and a new transaction is taken in every cycle while the result side keeps up;
// a stalled result holds the input register.
// The critical path is the 24 by 20 bit multiplier that forms the angle times steps per
// revolution product on a start; that product is kept as a step budget from which 5760 is
// taken on each step, so no divider is needed. Configuration writes are always accepted.

module stepper_phase_sequencer import sps_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  sps_cfg_if.sink cfg_chan,
  sps_in_if.sink  in_chan,
  sps_out_if.source out_chan
);

  logic [1:0]       mode_r;
  logic [SPR_W-1:0] half_steps_r;

  logic                      in_v_r;
  cmd_t                      in_cmd_r;
  logic signed [ANGLE_W-1:0] in_angle_r;
  logic [DELAY_W-1:0]        in_delay_r;

  logic               out_v_r;
  logic [COILS_W-1:0] out_coils_r;
  logic               out_running_r;
  logic               out_done_r;
  logic               out_status_r;

  logic [PHASE_W-1:0] phase_r,  phase_nxt;
  logic [ACC_W-1:0]   budget_r, budget_nxt;
  dir_t               dir_r,    dir_nxt;
  logic [DELAY_W-1:0] delay_r,  delay_nxt;
  logic [DELAY_W-1:0] tick_r,   tick_nxt;
  logic               active_r, active_nxt;
  logic [COILS_W-1:0] coil_r,   coil_nxt;
  logic               done_nxt;
  logic               status_nxt;

  logic advance;
  logic fire;

  logic               four_phase;
  logic [PHASE_W-1:0] phase_cur;
  logic [PHASE_W-1:0] phase_last;
  logic [PHASE_W-1:0] phase_step;
  logic [COILS_W-1:0] coils_step;
  logic [DELAY_W-1:0] tick_inc;

  logic               angle_neg;
  logic [ANGLE_W-1:0] angle_bits;
  logic [ANGLE_W-1:0] angle_mag;
  logic [SPR_W-1:0]   spr;
  logic [ACC_W-1:0]   product;
  logic               product_sat;

  assign advance       = !out_v_r || out_chan.ready;
  assign fire          = in_v_r && advance;
  assign in_chan.ready = !in_v_r || advance;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid    = out_v_r;
  assign out_chan.coils    = out_coils_r;
  assign out_chan.running  = out_running_r;
  assign out_chan.done_res = out_done_r;
  assign out_chan.status   = out_status_r;

  assign four_phase = (mode_r == MODE_WAVE) || (mode_r == MODE_FULL);
  assign phase_cur  = four_phase ? {1'b0, phase_r[1:0]} : phase_r;
  assign phase_last = four_phase ? 3'd3 : 3'd7;
  assign tick_inc   = tick_r + 1'b1;

  always_comb begin
    case (dir_r)
      DIR_FWD:  phase_step = (phase_cur == phase_last) ? '0 : phase_cur + 1'b1;
      DIR_BACK: phase_step = (phase_cur == '0) ? phase_last : phase_cur - 1'b1;
      default:  phase_step = phase_cur;
    endcase
  end

  always_comb begin
    case (mode_r)
      MODE_WAVE: coils_step = wave_pattern(phase_step[1:0]);
      MODE_FULL: coils_step = full_pattern(phase_step[1:0]);
      MODE_HALF: coils_step = half_pattern(phase_step);
      default:   coils_step = half_pattern(phase_step);
    endcase
  end

  assign angle_neg   = in_angle_r[ANGLE_W-1];
  assign angle_bits  = $unsigned(in_angle_r);
  assign angle_mag   = angle_neg ? (~angle_bits + 1'b1) : angle_bits;
  assign spr         = four_phase ? {1'b0, half_steps_r[SPR_W-1:1]} : half_steps_r;
  assign product     = angle_mag * spr;
  assign product_sat = 64'(product) > STEP_CAP;

  always_comb begin
    phase_nxt  = phase_r;
    budget_nxt = budget_r;
    dir_nxt    = dir_r;
    delay_nxt  = delay_r;
    tick_nxt   = tick_r;
    active_nxt = active_r;
    coil_nxt   = coil_r;
    done_nxt   = 1'b0;
    status_nxt = 1'b0;
    unique case (in_cmd_r)
      CMD_START: begin
        budget_nxt = product_sat ? STEP_CAP[ACC_W-1:0] : product;
        if (angle_bits == '0) begin
          dir_nxt = DIR_HOLD;
        end else if (angle_neg) begin
          dir_nxt = DIR_BACK;
        end else begin
          dir_nxt = DIR_FWD;
        end
        delay_nxt  = (in_delay_r == '0) ? DELAY_W'(1) : in_delay_r;
        tick_nxt   = '0;
        active_nxt = 1'b1;
      end
      CMD_CANCEL: begin
        if (active_r) begin
          active_nxt = 1'b0;
          coil_nxt   = '0;
          tick_nxt   = '0;
        end else begin
          status_nxt = 1'b1;
        end
      end
      CMD_TICK: begin
        if (active_r) begin
          tick_nxt = tick_inc;
          if (tick_inc >= delay_r) begin
            tick_nxt  = '0;
            phase_nxt = phase_step;
            coil_nxt  = coils_step;
            if (budget_r < FINISH_LIMIT) begin
              budget_nxt = '0;
              coil_nxt   = '0;
              active_nxt = 1'b0;
              done_nxt   = 1'b1;
            end else begin
              budget_nxt = budget_r - STEP_UNIT;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_HALF;
      half_steps_r <= HALF_STEPS_RESET;
      in_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      phase_r      <= '0;
      budget_r     <= '0;
      dir_r        <= DIR_HOLD;
      delay_r      <= DELAY_W'(1);
      tick_r       <= '0;
      active_r     <= 1'b0;
      coil_r       <= '0;
    end else begin
      if (cfg_chan.valid) begin
        unique case (cfg_chan.index)
          REG_COIL_MODE:  mode_r <= cfg_chan.data[1:0];
          REG_HALF_STEPS: half_steps_r <= cfg_chan.data[SPR_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_chan.ready) begin
        in_v_r <= in_chan.valid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
      if (fire) begin
        phase_r  <= phase_nxt;
        budget_r <= budget_nxt;
        dir_r    <= dir_nxt;
        delay_r  <= delay_nxt;
        tick_r   <= tick_nxt;
        active_r <= active_nxt;
        coil_r   <= coil_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_cmd_r   <= cmd_t'(in_chan.command);
      in_angle_r <= in_chan.angle_sixteenths;
      in_delay_r <= in_chan.step_delay_ms;
    end
    if (fire) begin
      out_coils_r   <= coil_nxt;
      out_running_r <= active_nxt;
      out_done_r    <= done_nxt;
      out_status_r  <= status_nxt;
    end
  end

endmodule

/* rtl/sps_checker.sv */
// Port-level checker for the stepper phase sequencer, bound to the top level below.
// Depends on stepper_phase_sequencer_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`include "stepper_phase_sequencer_defines.svh"

module sps_checker import sps_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COILS_W-1:0] out_coils,
  input logic               out_running,
  input logic               out_done_res,
  input logic               out_status
);

  // The coils may only be energised while a move is in progress.
  `SPS_ASSERT_IMP(a_idle_coils_off, out_valid && !out_running, out_coils == '0, "coils driven while idle")

  // A finishing transaction always leaves the move stopped.
  `SPS_ASSERT_IMP(a_done_stops, out_valid && out_done_res, !out_running, "done flagged with move still running")

  // A failed cancel can only occur with no move and no completion.
  `SPS_ASSERT_IMP(a_status_idle, out_valid && out_status, !out_running && !out_done_res, "cancel status with active move")

  // A result that is not taken stays unchanged.
  `SPS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_coils) && $stable(out_running) && $stable(out_done_res) && $stable(out_status), "stalled result changed")

endmodule

bind stepper_phase_sequencer sps_checker u_sps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_coils    (out_chan.coils),
  .out_running  (out_chan.running),
  .out_done_res (out_chan.done_res),
  .out_status   (out_chan.status)
);
